@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

@@ hw/rtl/rts_pkg.sv @@
package rts_pkg;

    localparam int SEC_W    = 17;
    localparam int ACTIVE_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_CREATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUTINE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTINE_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTINE_STOP   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SEC_W-1:0] start;
        logic [SEC_W-1:0] delay;
        logic             action;
    } t_slot;

    typedef struct packed {
        logic             enable;
        logic [SEC_W-1:0] start_sec;
        logic [SEC_W-1:0] stop_sec;
    } t_routine;

    typedef struct packed {
        logic                relay_on;
        logic                timer_created;
        logic [ACTIVE_W-1:0] active_timers;
        logic                timer_expired;
    } t_result;

endpackage

@@ hw/rtl/rts_slot_mem.sv @@
module rts_slot_mem #(
    parameter int TIMER_SLOTS = 10,
    parameter int IDXW        = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDXW-1:0]   i_waddr,
    input  rts_pkg::t_slot    i_wdata,
    input  logic              i_re,
    input  logic [IDXW-1:0]   i_raddr,
    output rts_pkg::t_slot    o_rdata
);
    import rts_pkg::*;

    t_slot r_mem [TIMER_SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rts_seq.sv @@
module rts_seq #(
    parameter int TIMER_SLOTS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [rts_pkg::SEC_W-1:0]    i_now_sec,
    input  logic [rts_pkg::SEC_W-1:0]    i_timer_delay,
    input  logic                         i_timer_action,
    input  rts_pkg::t_routine            i_routine,
    input  logic                         i_out_free,
    output logic                         o_emit,
    output rts_pkg::t_result             o_result
);
    import rts_pkg::*;

    localparam int IDXW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNTW = $clog2(TIMER_SLOTS + 1);

    t_state r_state, n_state;

    logic             r_op;
    logic [SEC_W-1:0] r_now;
    logic [SEC_W-1:0] r_delay;
    logic             r_action;

    logic [TIMER_SLOTS-1:0] r_live;
    logic [CNTW-1:0]        r_count;
    logic                   r_relay;
    logic                   r_created;
    logic                   r_expired;
    logic [CNTW-1:0]        r_rd_idx;
    logic                   r_chk_valid;
    logic [IDXW-1:0]        r_chk_idx;

    logic            accept;
    logic            do_create;
    logic            rd_en;
    logic            scan_last;
    logic            create_ok;
    logic            free_any;
    logic [IDXW-1:0] free_idx;
    logic            fire;
    logic [SEC_W:0]  elapsed;
    logic [CNTW+ACTIVE_W-1:0] cnt_ext;
    t_slot           wr_slot;
    t_slot           rd_slot;

    rts_slot_mem #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .IDXW        (IDXW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (do_create),
        .i_waddr (free_idx),
        .i_wdata (wr_slot),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDXW-1:0]),
        .o_rdata (rd_slot)
    );

    // The highest-numbered free slot takes a new timer.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            if (!r_live[k]) begin
                free_any = 1'b1;
                free_idx = IDXW'(k);
            end
        end
    end

    assign create_ok = (r_delay != '0) && (r_count < CNTW'(TIMER_SLOTS)) && free_any;

    assign wr_slot.start  = r_now;
    assign wr_slot.delay  = r_delay;
    assign wr_slot.action = r_action;

    // A start later than now means the elapsed time wrapped, which always fires.
    assign elapsed = {1'b0, r_now} - {1'b0, rd_slot.start};
    assign fire    = r_chk_valid && r_live[r_chk_idx]
                   && (elapsed[SEC_W] || (elapsed[SEC_W-1:0] >= rd_slot.delay));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_operation == OP_CREATE) ? ST_CREATE : ST_SCAN;
                end
            end
            ST_CREATE: n_state = ST_EMIT;
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        accept     = (r_state == ST_IDLE) && i_in_valid;
        do_create  = (r_state == ST_CREATE) && create_ok;
        rd_en      = (r_state == ST_SCAN) && (r_rd_idx < CNTW'(TIMER_SLOTS));
        scan_last  = (r_state == ST_SCAN) && r_chk_valid
                   && (r_chk_idx == IDXW'(TIMER_SLOTS - 1));
        o_emit     = (r_state == ST_EMIT) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_count     <= '0;
            r_relay     <= 1'b0;
            r_created   <= 1'b0;
            r_expired   <= 1'b0;
            r_rd_idx    <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= rd_en;
            if (accept) begin
                r_created <= 1'b0;
                r_expired <= 1'b0;
                r_rd_idx  <= '0;
                // The daily routine acts before any timer on a tick.
                if ((i_operation == OP_TICK) && i_routine.enable) begin
                    if (i_routine.start_sec == i_now_sec) begin
                        r_relay <= 1'b1;
                    end else if (i_routine.stop_sec == i_now_sec) begin
                        r_relay <= 1'b0;
                    end
                end
            end
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (do_create) begin
                r_live[free_idx] <= 1'b1;
                r_count          <= r_count + 1'b1;
                r_created        <= 1'b1;
            end
            if (fire) begin
                r_relay           <= rd_slot.action;
                r_live[r_chk_idx] <= 1'b0;
                r_count           <= r_count - 1'b1;
                r_expired         <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_rd_idx[IDXW-1:0];
        if (accept) begin
            r_op     <= i_operation;
            r_now    <= i_now_sec;
            r_delay  <= i_timer_delay;
            r_action <= i_timer_action;
        end
    end

    assign cnt_ext = {{ACTIVE_W{1'b0}}, r_count};

    assign o_result.relay_on      = r_relay;
    assign o_result.timer_created = r_created && (r_op == OP_CREATE);
    assign o_result.active_timers = cnt_ext[ACTIVE_W-1:0];
    assign o_result.timer_expired = r_expired && (r_op == OP_TICK);

endmodule

@@ hw/rtl/relay_timer_scheduler_core.sv @@
// Relay timer scheduler: one relay driven by a table of one-shot timers and a daily
// on/off routine.
// Input channel (i_in_valid / o_in_stall): one item per transfer, either a tick
// carrying the second of the day or a request to create a timer.
// Output channel (o_out_valid / i_out_stall): exactly one result per item, giving the
// relay level, whether a timer was created, the live timer count and whether any
// timer fired.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; index 0 enables
// the routine, 1 and 2 set its start and stop seconds. Write only while idle.
// A create item passes through the create and emit states into the output register.
// A tick item walks the slot memory through its single read port, one slot a cycle,
// then passes through the emit state into the output register.
// One item is worked on at a time; the next item is taken as soon as the previous
// result sits in the output register, even if the receiver has not yet taken it.
// While the receiver stalls the result holds, and a finished item waits for the
// output register before it is handed over.
// Synchronous reset clears every timer, turns the relay off and clears the routine.
module relay_timer_scheduler_core #(
    parameter int TIMER_SLOTS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [rts_pkg::SEC_W-1:0]       i_now_sec,
    input  logic [rts_pkg::SEC_W-1:0]       i_timer_delay,
    input  logic                            i_timer_action,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_relay_on,
    output logic                            o_timer_created,
    output logic [rts_pkg::ACTIVE_W-1:0]    o_active_timers,
    output logic                            o_timer_expired,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rts_pkg::SEC_W-1:0]       i_cfg_data
);
    import rts_pkg::*;

    t_routine r_routine;
    logic     r_out_valid;
    t_result  r_out;
    logic     out_free;
    logic     emit;
    t_result  result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_routine <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROUTINE_ENABLE: r_routine.enable    <= i_cfg_data[0];
                CFG_ROUTINE_START:  r_routine.start_sec <= i_cfg_data;
                CFG_ROUTINE_STOP:   r_routine.stop_sec  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rts_seq #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_now_sec      (i_now_sec),
        .i_timer_delay  (i_timer_delay),
        .i_timer_action (i_timer_action),
        .i_routine      (r_routine),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_result       (result)
    );

    // The output register is free when empty or when its result is being taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relay_on      = r_out.relay_on;
    assign o_timer_created = r_out.timer_created;
    assign o_active_timers = r_out.active_timers;
    assign o_timer_expired = r_out.timer_expired;

endmodule

@@ hw/rtl/rts_checker.sv @@
`include "assert_macros.svh"

module rts_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_relay_on,
    input  logic                         o_timer_created,
    input  logic [rts_pkg::ACTIVE_W-1:0] o_active_timers,
    input  logic                         o_timer_expired
);

    // A result never reports both a creation and an expiry.
    `ASSERT_NEVER(a_created_and_expired, i_clk, i_rst_n, o_out_valid && o_timer_created && o_timer_expired, "result reports both creation and expiry")

    // Items are worked on one at a time, so the block is busy after each transfer.
    `ASSERT_PROP(a_busy_after_transfer, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input taken again straight after a transfer")

    `ASSERT_PROP(a_result_held, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_relay_on) && $stable(o_timer_created) && $stable(o_active_timers) && $stable(o_timer_expired)), "stalled result changed")

endmodule

bind relay_timer_scheduler_core rts_checker u_rts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_relay_on      (o_relay_on),
    .o_timer_created (o_timer_created),
    .o_active_timers (o_active_timers),
    .o_timer_expired (o_timer_expired)
);

@@ test/relay_timer_scheduler_core_tb.sv @@
module relay_timer_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rts_pkg::*;

    localparam int SLOTS          = 10;
    localparam int DAY_SECONDS    = 86400;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_operation;
    logic [SEC_W-1:0]     i_now_sec;
    logic [SEC_W-1:0]     i_timer_delay;
    logic                 i_timer_action;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_relay_on;
    logic                 o_timer_created;
    logic [ACTIVE_W-1:0]  o_active_timers;
    logic                 o_timer_expired;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SEC_W-1:0]     i_cfg_data;

    // Predicted timer table, relay and routine settings.
    logic [SEC_W-1:0] sched_start [SLOTS];
    logic [SEC_W-1:0] sched_delay [SLOTS];
    logic             sched_action [SLOTS];
    logic             sched_relay = 1'b0;
    int               sched_live = 0;
    logic             rt_enable = 1'b0;
    logic [SEC_W-1:0] rt_start = '0;
    logic [SEC_W-1:0] rt_stop = '0;

    t_result expected_results[$];
    int      fail_count = 0;
    int      results_seen = 0;
    int      sim_now = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    int      rx_hold_cycles = 0;
    int      idle_cycles;

    relay_timer_scheduler_core #(
        .TIMER_SLOTS(SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_now_sec      (i_now_sec),
        .i_timer_delay  (i_timer_delay),
        .i_timer_action (i_timer_action),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_relay_on     (o_relay_on),
        .o_timer_created(o_timer_created),
        .o_active_timers(o_active_timers),
        .o_timer_expired(o_timer_expired),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            sched_start[k]  = '0;
            sched_delay[k]  = '0;
            sched_action[k] = 1'b0;
        end
    end

    function automatic t_result advance_scheduler(input logic op, input logic [SEC_W-1:0] now_v,
                                                  input logic [SEC_W-1:0] dly_v,
                                                  input logic act_v);
        t_result     res;
        int          free_slot;
        logic [31:0] elapsed;
        res = '0;
        if (op == OP_CREATE) begin
            free_slot = -1;
            for (int k = 0; k < SLOTS; k++)
                if (sched_delay[k] == '0) free_slot = k;
            if (dly_v != '0 && sched_live < SLOTS && free_slot >= 0) begin
                sched_start[free_slot]  = now_v;
                sched_delay[free_slot]  = dly_v;
                sched_action[free_slot] = act_v;
                sched_live++;
                res.timer_created = 1'b1;
            end
        end else begin
            if (rt_enable) begin
                if (rt_start == now_v) sched_relay = 1'b1;
                else if (rt_stop == now_v) sched_relay = 1'b0;
            end
            // Ascending order, so the highest firing slot leaves its action on the relay.
            for (int k = 0; k < SLOTS; k++) begin
                if (sched_delay[k] != '0) begin
                    elapsed = 32'(now_v) - 32'(sched_start[k]);
                    if (elapsed >= 32'(sched_delay[k])) begin
                        sched_relay    = sched_action[k];
                        sched_delay[k] = '0;
                        if (sched_live > 0) sched_live--;
                        res.timer_expired = 1'b1;
                    end
                end
            end
        end
        res.relay_on      = sched_relay;
        res.active_timers = ACTIVE_W'(sched_live);
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        fail_count++;
    endtask

    task automatic send_item(input logic op, input logic [SEC_W-1:0] now_v,
                             input logic [SEC_W-1:0] dly_v, input logic act_v);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_now_sec      <= now_v;
        i_timer_delay  <= dly_v;
        i_timer_action <= act_v;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(advance_scheduler(op, now_v, dly_v, act_v));
    endtask

    task automatic drain_outputs(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROUTINE_ENABLE: rt_enable = data[0];
            CFG_ROUTINE_START:  rt_start  = data;
            CFG_ROUTINE_STOP:   rt_stop   = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_routine(input logic en, input logic [SEC_W-1:0] start_v,
                                 input logic [SEC_W-1:0] stop_v);
        drain_outputs(SETTLE_CYCLES);
        write_reg(CFG_ROUTINE_ENABLE, SEC_W'(en));
        write_reg(CFG_ROUTINE_START, start_v);
        write_reg(CFG_ROUTINE_STOP, stop_v);
    endtask

    // Mostly creates at the running second of the day and ticks that walk it forward,
    // so that timers regularly expire; a small share of items is unrelated noise.
    task automatic send_random_item();
        int               pick;
        logic [SEC_W-1:0] dly_v;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_item(1'($urandom_range(0, 1)), SEC_W'($urandom_range(0, DAY_SECONDS - 1)),
                      SEC_W'($urandom_range(0, DAY_SECONDS)), 1'($urandom_range(0, 1)));
        end else if (pick < 45) begin
            case ($urandom_range(0, 9))
                0: dly_v = '0;
                1: dly_v = SEC_W'($urandom_range(1, DAY_SECONDS));
                default: dly_v = SEC_W'($urandom_range(1, 25));
            endcase
            send_item(OP_CREATE, SEC_W'(sim_now), dly_v, 1'($urandom_range(0, 1)));
        end else begin
            pick = $urandom_range(0, 39);
            if (pick == 0) sim_now = $urandom_range(0, DAY_SECONDS - 1);
            else if (pick < 3 && rt_start < DAY_SECONDS) sim_now = rt_start;
            else if (pick < 5 && rt_stop < DAY_SECONDS) sim_now = rt_stop;
            else sim_now = (sim_now + $urandom_range(0, 6)) % DAY_SECONDS;
            send_item(OP_TICK, SEC_W'(sim_now), SEC_W'($urandom_range(0, DAY_SECONDS)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(input int count);
        if (rt_start < DAY_SECONDS) sim_now = (rt_start + DAY_SECONDS - 20) % DAY_SECONDS;
        else sim_now = $urandom_range(0, DAY_SECONDS - 1);
        for (int k = 0; k < count; k++) send_random_item();
    endtask

    task automatic test_timer_table();
        send_item(OP_CREATE, 17'd0, 17'd0, 1'b1);
        send_item(OP_CREATE, 17'd100, 17'(DAY_SECONDS), 1'b1);
        send_item(OP_CREATE, 17'd100, 17'd1, 1'b0);
        send_item(OP_TICK, 17'd100, 17'd0, 1'b0);
        send_item(OP_TICK, 17'd101, 17'h1FFFF, 1'b1);
        // Fill every slot, then one more create that must be refused.
        for (int k = 0; k < 9; k++)
            send_item(OP_CREATE, 17'd200, SEC_W'((k % 3) + 3), 1'(k));
        send_item(OP_CREATE, 17'd200, 17'd7, 1'b1);
        send_item(OP_TICK, 17'd202, 17'd0, 1'b0);
        send_item(OP_TICK, 17'd204, 17'd0, 1'b0);
        send_item(OP_TICK, 17'd210, 17'd0, 1'b0);
        // A tick earlier than the start second wraps the elapsed time and fires.
        send_item(OP_CREATE, 17'(DAY_SECONDS - 1), 17'd10, 1'b1);
        send_item(OP_TICK, 17'd0, 17'd0, 1'b0);
    endtask

    task automatic test_routine_edges();
        apply_routine(1'b1, 17'(DAY_SECONDS - 1), 17'd0);
        send_item(OP_TICK, 17'(DAY_SECONDS - 1), 17'd0, 1'b0);
        send_item(OP_TICK, 17'd0, 17'd0, 1'b0);
        apply_routine(1'b1, 17'd500, 17'd500);
        send_item(OP_TICK, 17'd500, 17'd0, 1'b0);
        apply_routine(1'b0, 17'd500, 17'd0);
        send_item(OP_TICK, 17'd0, 17'd0, 1'b0);
        apply_routine(1'b1, 17'h1FFFF, 17'h1FFFF);
        send_item(OP_TICK, 17'(DAY_SECONDS - 1), 17'd0, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [SEC_W-1:0] sec_v;
        for (int phase = 0; phase < 5; phase++) begin
            sec_v = SEC_W'($urandom_range(0, DAY_SECONDS - 1));
            case (phase)
                0: apply_routine(1'b0, '0, '0);
                1: apply_routine(1'b1, '0, 17'(DAY_SECONDS - 1));
                2: apply_routine(1'b1, sec_v, SEC_W'($urandom_range(0, DAY_SECONDS - 1)));
                3: apply_routine(1'b1, sec_v, sec_v);
                default: apply_routine(1'b1, 17'h1FFFF, sec_v);
            endcase
            run_random(200);
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        for (int k = 0; k < 20; k++) send_random_item();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 15; j++) send_random_item();
            drain_outputs(0);
        end
    endtask

    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_routine(1'b1, SEC_W'($urandom_range(0, DAY_SECONDS - 1)),
                      SEC_W'($urandom_range(0, DAY_SECONDS - 1)));
        run_random(200);
    endtask

    // Receiver: random stall bursts, or one long hold when a test asks for it.
    always begin
        @(posedge i_clk);
        if (rx_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            repeat (rx_hold_cycles) @(posedge i_clk);
            rx_hold_cycles = 0;
            i_out_stall <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_error("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (o_relay_on !== want.relay_on)
                    report_error($sformatf("relay_on %0d, want %0d", o_relay_on,
                                           want.relay_on));
                if (o_timer_created !== want.timer_created)
                    report_error($sformatf("timer_created %0d, want %0d", o_timer_created,
                                           want.timer_created));
                if (o_active_timers !== want.active_timers)
                    report_error($sformatf("active_timers %0d, want %0d", o_active_timers,
                                           want.active_timers));
                if (o_timer_expired !== want.timer_expired)
                    report_error($sformatf("timer_expired %0d, want %0d", o_timer_expired,
                                           want.timer_expired));
            end
        end
    end

    // Ends the run when no transfer of any kind has happened for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_TICK;
        i_now_sec      = '0;
        i_timer_delay  = '0;
        i_timer_action = 1'b0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ROUTINE_ENABLE;
        i_cfg_data     = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_timer_table();
        test_routine_edges();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        drain_outputs(SETTLE_CYCLES);
        if (expected_results.size() != 0)
            report_error("results still expected at the end");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ relay_timer_scheduler_core.f @@
+incdir+hw/rtl
hw/rtl/rts_pkg.sv
hw/rtl/rts_slot_mem.sv
hw/rtl/rts_seq.sv
hw/rtl/relay_timer_scheduler_core.sv
hw/rtl/rts_checker.sv
test/relay_timer_scheduler_core_tb.sv
